>>> rtl/sfwh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwh_pkg: shared definitions for the symmetric flow worker hash unit
// Field widths, hash constants, pipeline depths and the beat type that
// travels from the hash pipeline to the modulo pipeline.
// ----------------------------------------------------------------------------
package sfwh_pkg;

  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned PORT_W         = 16;
  localparam int unsigned PROTO_W        = 8;
  localparam int unsigned HASH_W         = 32;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned WORKER_INDEX_W = 10;

  localparam logic [COUNT_W-1:0] MAX_WORKERS        = COUNT_W'(1024);
  localparam logic [COUNT_W-1:0] WORKER_COUNT_RESET = COUNT_W'(1);

  localparam logic [HASH_W-1:0] MIX_MUL_A = 32'h85eb_ca6b;
  localparam logic [HASH_W-1:0] MIX_MUL_B = 32'hc2b2_ae35;
  localparam int unsigned       MIX_SHIFT_WIDE   = 16;
  localparam int unsigned       MIX_SHIFT_NARROW = 13;
  localparam int unsigned       FOLD_SHIFT       = 5;   // times 32, minus one copy

  localparam int unsigned HASH_STAGES = 7;
  localparam int unsigned DIV_BITS    = 4;
  localparam int unsigned MOD_STAGES  = HASH_W / DIV_BITS;
  localparam int unsigned LATENCY     = HASH_STAGES + MOD_STAGES;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } hash_beat_t;

endpackage

>>> rtl/sfwh_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwh_hash: seven-stage flow hash pipeline
// Orders the ports, folds the tuple with multiply-by-31-and-add and runs the
// murmur3 32-bit finalizer, with its two multiplies in separate stages.
// ----------------------------------------------------------------------------
module sfwh_hash (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [sfwh_pkg::ADDR_W-1:0]  source_address_i,
  input  logic [sfwh_pkg::ADDR_W-1:0]  destination_address_i,
  input  logic [sfwh_pkg::PORT_W-1:0]  source_port_i,
  input  logic [sfwh_pkg::PORT_W-1:0]  destination_port_i,
  input  logic [sfwh_pkg::PROTO_W-1:0] protocol_number_i,
  output sfwh_pkg::hash_beat_t         hash_o
);
  import sfwh_pkg::*;

  function automatic logic [HASH_W-1:0] fold31(input logic [HASH_W-1:0] h,
                                               input logic [HASH_W-1:0] x);
    return (h << FOLD_SHIFT) - h + x;
  endfunction

  logic [HASH_STAGES-1:0] valid_q;

  logic [HASH_W-1:0]  s1_hash_q, s2_hash_q, s3_hash_q, s4_hash_q;
  logic [HASH_W-1:0]  s5_hash_q, s6_hash_q, s7_hash_q;
  logic [PORT_W-1:0]  s1_lo_port_q, s1_hi_port_q, s2_hi_port_q;
  logic [PROTO_W-1:0] s1_proto_q, s2_proto_q, s3_proto_q;

  logic [HASH_W-1:0] s1_hash_d, s4_hash_d, s4_hash_mix, s6_hash_mix, s7_hash_d;
  logic              port_swap;

  // The address XOR is symmetric already, so only the ports need ordering.
  assign s1_hash_d   = source_address_i ^ destination_address_i;
  assign port_swap   = destination_port_i < source_port_i;
  assign s4_hash_d   = fold31(s3_hash_q, HASH_W'(s3_proto_q));
  assign s4_hash_mix = s4_hash_d ^ (s4_hash_d >> MIX_SHIFT_WIDE);
  assign s6_hash_mix = s5_hash_q ^ (s5_hash_q >> MIX_SHIFT_NARROW);
  assign s7_hash_d   = s6_hash_q ^ (s6_hash_q >> MIX_SHIFT_WIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[HASH_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    s1_hash_q    <= s1_hash_d;
    s1_lo_port_q <= port_swap ? destination_port_i : source_port_i;
    s1_hi_port_q <= port_swap ? source_port_i : destination_port_i;
    s1_proto_q   <= protocol_number_i;

    s2_hash_q    <= fold31(s1_hash_q, HASH_W'(s1_lo_port_q));
    s2_hi_port_q <= s1_hi_port_q;
    s2_proto_q   <= s1_proto_q;

    s3_hash_q    <= fold31(s2_hash_q, HASH_W'(s2_hi_port_q));
    s3_proto_q   <= s2_proto_q;

    s4_hash_q    <= s4_hash_mix;
    s5_hash_q    <= s4_hash_q * MIX_MUL_A;
    s6_hash_q    <= s6_hash_mix * MIX_MUL_B;
    s7_hash_q    <= s7_hash_d;
  end

  assign hash_o.valid = valid_q[HASH_STAGES-1];
  assign hash_o.hash  = s7_hash_q;

endmodule

>>> rtl/sfwh_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfwh_mod: pipelined modulo by the worker count
// Restoring remainder computation, four dividend bits per stage over eight
// stages; the quotient is never formed.
// ----------------------------------------------------------------------------
module sfwh_mod (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sfwh_pkg::hash_beat_t                hash_i,
  input  logic [sfwh_pkg::COUNT_W-1:0]        count_i,
  output logic                                done_o,
  output logic [sfwh_pkg::WORKER_INDEX_W-1:0] worker_index_o
);
  import sfwh_pkg::*;

  // The remainder stays below the count, which is at most MAX_WORKERS, so a
  // shifted remainder fits the count width and one subtract restores it.
  function automatic logic [WORKER_INDEX_W-1:0] mod_step(
    input logic [WORKER_INDEX_W-1:0] rem,
    input logic [DIV_BITS-1:0]       bits,
    input logic [COUNT_W-1:0]        cnt
  );
    logic [COUNT_W-1:0]        t;
    logic [WORKER_INDEX_W-1:0] r;
    r = rem;
    for (int k = DIV_BITS - 1; k >= 0; k--) begin
      t = {r, bits[k]};
      if (t >= cnt) begin
        t = t - cnt;
      end
      r = t[WORKER_INDEX_W-1:0];
    end
    return r;
  endfunction

  logic                      valid_q [MOD_STAGES];
  logic [HASH_W-1:0]         dvd_q   [MOD_STAGES];
  logic [WORKER_INDEX_W-1:0] rem_q   [MOD_STAGES];

  for (genvar s = 0; s < MOD_STAGES; s++) begin : g_stage
    logic                      valid_in;
    logic [HASH_W-1:0]         dvd_in;
    logic [WORKER_INDEX_W-1:0] rem_in;

    if (s == 0) begin : g_first
      assign valid_in = hash_i.valid;
      assign dvd_in   = hash_i.hash;
      assign rem_in   = '0;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign dvd_in   = dvd_q[s-1];
      assign rem_in   = rem_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dvd_q[s] <= dvd_in << DIV_BITS;
      rem_q[s] <= mod_step(rem_in, dvd_in[HASH_W-1 -: DIV_BITS], count_i);
    end
  end

  // A count of zero selects worker 0; a count of one gives 0 by itself.
  assign done_o         = valid_q[MOD_STAGES-1];
  assign worker_index_o = (count_i == '0) ? '0 : rem_q[MOD_STAGES-1];

endmodule

>>> rtl/symmetric_flow_worker_hash_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// symmetric_flow_worker_hash_unit: symmetric five-tuple to worker steering
// Hashes a flow five-tuple so both directions agree, mixes it with the
// murmur3 finalizer and reduces it modulo the configured worker count.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  -------   ---------------------------  -----------------------------------
//  input     start high, busy low         addresses, ports, protocol number
//  result    done_o strobe, one cycle     worker_index_o
//  config    worker_count_we_i            worker_count_wdata_i (11 bits)
//
//  One tuple is taken every cycle; each result passes through the 7 hash
//  stages, then the 8 modulo stages of 4 bits each.
//  busy is always low: the pipeline never stalls and the receiver cannot
//  hold results off, so nothing waits inside.
//  Reset clears the stage valid bits and sets the worker count to 1.
//  Counts above 1024 are used as 1024; counts of 0 or 1 give worker 0.
// ----------------------------------------------------------------------------
module symmetric_flow_worker_hash_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [sfwh_pkg::ADDR_W-1:0]         source_address_i,
  input  logic [sfwh_pkg::ADDR_W-1:0]         destination_address_i,
  input  logic [sfwh_pkg::PORT_W-1:0]         source_port_i,
  input  logic [sfwh_pkg::PORT_W-1:0]         destination_port_i,
  input  logic [sfwh_pkg::PROTO_W-1:0]        protocol_number_i,
  output logic                                done_o,
  output logic [sfwh_pkg::WORKER_INDEX_W-1:0] worker_index_o,
  input  logic                                worker_count_we_i,
  input  logic [sfwh_pkg::COUNT_W-1:0]        worker_count_wdata_i
);
  import sfwh_pkg::*;

  logic [COUNT_W-1:0] worker_count_q, worker_count_d;
  logic [COUNT_W-1:0] count_eff;
  logic               accept;
  hash_beat_t         hash_beat;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign worker_count_d = worker_count_we_i ? worker_count_wdata_i : worker_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      worker_count_q <= WORKER_COUNT_RESET;
    end else begin
      worker_count_q <= worker_count_d;
    end
  end

  // The register keeps the written value; only the count in use saturates.
  assign count_eff = (worker_count_q > MAX_WORKERS) ? MAX_WORKERS : worker_count_q;

  sfwh_hash u_hash (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .valid_i               (accept),
    .source_address_i      (source_address_i),
    .destination_address_i (destination_address_i),
    .source_port_i         (source_port_i),
    .destination_port_i    (destination_port_i),
    .protocol_number_i     (protocol_number_i),
    .hash_o                (hash_beat)
  );

  sfwh_mod u_mod (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hash_i         (hash_beat),
    .count_i        (count_eff),
    .done_o         (done_o),
    .worker_index_o (worker_index_o)
  );

  // Every transfer produces exactly one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LATENCY done_o)
    else $error("transfer did not produce a result after the pipeline latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, LATENCY))
    else $error("result strobe without a matching transfer");

  // The hash stage hands a beat to the modulo pipeline in lockstep with the input.
  a_hash_timing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_beat.valid |-> $past(accept, HASH_STAGES))
    else $error("hash beat out of step with the transfers");

endmodule
